/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the rtl; every property uses clk and rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mppt_pkg.sv */
// ----------------------------------------------------------------------------
// mppt_pkg
// Shared types, widths and register codes of the adaptive-step tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mppt_pkg;

  // default sizes of internal storage
  localparam int DAC_BITS_DEF = 12;
  localparam int SUM_BITS_DEF = 48;

  // fixed field widths
  localparam int VSUM_W   = 40;
  localparam int WPOW_W   = 48;
  localparam int STEP_W   = 12;
  localparam int CODE_W   = 12;
  localparam int RUN_W    = 8;
  localparam int BUS_W    = 15;
  localparam int SHUNT_W  = 16;
  localparam int PROD_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [STEP_W-1:0] STEP_TOP = 12'hfff;
  localparam logic [RUN_W-1:0]  RUN_TOP  = 8'hff;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT = 2'd2;

  // configuration reset values
  localparam logic [STEP_W-1:0] MIN_STEP_RST  = 12'd1;
  localparam logic [STEP_W-1:0] MAX_STEP_RST  = 12'd16;
  localparam logic [RUN_W-1:0]  RUN_LIMIT_RST = 8'd4;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_DECIDE = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [BUS_W-1:0]          bus_sample;
    logic signed [SHUNT_W-1:0] shunt_sample;
  } mppt_in_t;

  typedef struct packed {
    logic [CODE_W-1:0]        dac_code;
    logic [STEP_W-1:0]        step_size;
    logic                     direction_up;
    logic signed [WPOW_W-1:0] window_power;
    logic [VSUM_W-1:0]        window_voltage;
  } mppt_out_t;

  // registered request between the input stage and the datapath
  typedef struct packed {
    logic                     decide;
    logic [BUS_W-1:0]         bus;
    logic signed [PROD_W-1:0] prod;
  } mppt_stage_t;

  // per-cycle strobes for the datapath
  typedef struct packed {
    logic sample_en;
    logic decide_en;
  } mppt_ctrl_t;

  // tracker decision handed to the result register
  typedef struct packed {
    logic [CODE_W-1:0] dac_code;
    logic [STEP_W-1:0] step_size;
    logic              direction_up;
  } mppt_trk_t;

endpackage

`default_nettype wire

/* rtl/mppt_in_stage.sv */
// ----------------------------------------------------------------------------
// mppt_in_stage
// Input register: captures a request and its shunt by bus product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mppt_in_stage import mppt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire mppt_in_t    in_data,
  input  wire logic        advance,
  output logic             st_valid,
  output mppt_stage_t      st_data
);

  logic                     valid_r;
  mppt_stage_t              data_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [SHUNT_W-1:0] bus_s;

  // unsigned bus voltage as a non-negative signed operand
  assign bus_s = signed'({1'b0, in_data.bus_sample});
  assign prod  = PROD_W'(in_data.shunt_sample) * PROD_W'(bus_s);

  // free slot or the held request moves on this cycle
  assign in_ready = !valid_r || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r.decide <= (in_data.req_type == REQ_DECIDE);
      data_r.bus    <= in_data.bus_sample;
      data_r.prod   <= prod;
    end
  end

  assign st_valid = valid_r;
  assign st_data  = data_r;

endmodule

`default_nettype wire

/* rtl/mppt_accum.sv */
// ----------------------------------------------------------------------------
// mppt_accum
// Saturating power and voltage window sums, cleared at each decision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mppt_accum import mppt_pkg::*; #(
  parameter int SUM_BITS = SUM_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mppt_ctrl_t           ctrl,
  input  wire mppt_stage_t          st_data,
  output logic signed [SUM_BITS-1:0] power_sum,
  output logic [VSUM_W-1:0]          voltage_sum
);

  localparam logic signed [SUM_BITS-1:0] PSUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] PSUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic signed [SUM_BITS-1:0] psum_r;
  logic signed [SUM_BITS-1:0] psum_nxt;
  logic signed [SUM_BITS:0]   p_add;
  logic [VSUM_W-1:0]          vsum_r;
  logic [VSUM_W-1:0]          vsum_nxt;
  logic [VSUM_W:0]            v_add;

  // power sum with saturation on signed overflow
  assign p_add = (SUM_BITS+1)'(psum_r) + (SUM_BITS+1)'(st_data.prod);
  always_comb begin
    if (p_add[SUM_BITS] != p_add[SUM_BITS-1]) begin
      psum_nxt = p_add[SUM_BITS] ? PSUM_MIN : PSUM_MAX;
    end else begin
      psum_nxt = p_add[SUM_BITS-1:0];
    end
  end

  // voltage sum with saturation at all ones
  assign v_add    = (VSUM_W+1)'(vsum_r) + (VSUM_W+1)'(st_data.bus);
  assign vsum_nxt = v_add[VSUM_W] ? {VSUM_W{1'b1}} : v_add[VSUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psum_r <= '0;
      vsum_r <= '0;
    end else if (ctrl.decide_en) begin
      psum_r <= '0;
      vsum_r <= '0;
    end else if (ctrl.sample_en) begin
      psum_r <= psum_nxt;
      vsum_r <= vsum_nxt;
    end
  end

  assign power_sum   = psum_r;
  assign voltage_sum = vsum_r;

endmodule

`default_nettype wire

/* rtl/mppt_track.sv */
// ----------------------------------------------------------------------------
// mppt_track
// Perturb and observe decision: direction, adaptive step and DAC code
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mppt_track import mppt_pkg::*; #(
  parameter int DAC_BITS = DAC_BITS_DEF,
  parameter int SUM_BITS = SUM_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  decide_en,
  input  wire logic [STEP_W-1:0]     min_step,
  input  wire logic [STEP_W-1:0]     max_step,
  input  wire logic [RUN_W-1:0]      run_limit,
  input  wire logic signed [SUM_BITS-1:0] power_sum,
  output mppt_trk_t                  trk
);

  localparam int AW = ((DAC_BITS > STEP_W) ? DAC_BITS : STEP_W) + 1;
  localparam logic [AW-1:0] DAC_TOP = AW'((2 ** DAC_BITS) - 1);

  logic signed [SUM_BITS-1:0] prev_r;
  logic [DAC_BITS-1:0]        dac_r;
  logic [DAC_BITS-1:0]        dac_nxt;
  logic [STEP_W-1:0]          step_r;
  logic [STEP_W-1:0]          step_nxt;
  logic                       dir_r;
  logic                       dir_nxt;
  logic                       dirb_r;
  logic                       dirb_nxt;
  logic [RUN_W-1:0]           run_r;
  logic [RUN_W-1:0]           run_nxt;

  logic                       drop;
  logic [RUN_W-1:0]           run_obs;
  logic [STEP_W-1:0]          floor_v;
  logic [STEP_W-1:0]          half;
  logic [STEP_W:0]            dbl;
  logic [AW-1:0]              dac_up;
  logic [AW-1:0]              dac_w;
  logic [AW-1:0]              step_w;

  // observe: a power drop reverses the direction and restarts the run
  assign drop    = power_sum < prev_r;
  assign dir_nxt = dir_r ^ drop;
  always_comb begin
    if (drop) begin
      run_obs = '0;
    end else if (run_r != RUN_TOP) begin
      run_obs = run_r + RUN_W'(1);
    end else begin
      run_obs = run_r;
    end
  end

  // adapt the step
  assign floor_v = (min_step == '0) ? STEP_W'(1) : min_step;
  assign half    = step_r >> 1;
  assign dbl     = {step_r, 1'b0};
  always_comb begin
    step_nxt = step_r;
    run_nxt  = run_obs;
    dirb_nxt = dirb_r;
    if (dir_nxt == dirb_r) begin
      if (run_obs >= run_limit) begin
        if (step_r < max_step) begin
          step_nxt = dbl[STEP_W] ? STEP_TOP : dbl[STEP_W-1:0];
        end
        run_nxt = '0;
      end
    end else begin
      if (step_r > min_step) begin
        step_nxt = (half < floor_v) ? floor_v : half;
      end
      if (step_nxt == '0) begin
        step_nxt = STEP_W'(1);
      end
      dirb_nxt = dir_nxt;
    end
  end

  // move the DAC code, clamped to its range
  assign dac_w  = AW'(dac_r);
  assign step_w = AW'(step_nxt);
  assign dac_up = dac_w + step_w;
  always_comb begin
    if (dir_nxt) begin
      dac_nxt = (dac_up < DAC_TOP) ? dac_up[DAC_BITS-1:0] : DAC_TOP[DAC_BITS-1:0];
    end else if (dac_w > step_w) begin
      dac_nxt = DAC_BITS'(dac_w - step_w);
    end else begin
      dac_nxt = '0;
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      dac_r  <= '0;
      step_r <= MIN_STEP_RST;
      dir_r  <= 1'b1;
      dirb_r <= 1'b1;
      run_r  <= '0;
    end else if (decide_en) begin
      prev_r <= power_sum;
      dac_r  <= dac_nxt;
      step_r <= step_nxt;
      dir_r  <= dir_nxt;
      dirb_r <= dirb_nxt;
      run_r  <= run_nxt;
    end
  end

  assign trk.dac_code     = CODE_W'(dac_nxt);
  assign trk.step_size    = step_nxt;
  assign trk.direction_up = dir_nxt;

endmodule

`default_nettype wire

/* rtl/mppt_perturb_observe_adaptive_step.sv */
// ----------------------------------------------------------------------------
// mppt_perturb_observe_adaptive_step
// Maximum power point tracker, perturb and observe with adaptive step
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready request channel; req_type sample adds one bus and
//           shunt reading to the window, req_type decide closes the window.
//   out_* : valid/ready result channel; one result per decide request with
//           the new DAC code, the step used, the direction and both sums.
//   cfg_* : write-only register port (min_step, max_step, run_limit), to be
//           written while no request is in flight.
// Timing:
//   one request per cycle sustained while no decide is held; a decide result
//   reaches out_data through the input register, loaded when the request is
//   taken, and then the result register, loaded when the decide moves on.
//   Sample requests produce no result and never wait on the result channel.
// Stall:
//   a result waits in the result register while out_ready is low; samples
//   keep flowing, and a following decide holds in the input register until
//   the result register is taken.
// Reset:
//   synchronous, active low; sums, run count and DAC code clear, the direction
//   returns to up, the step to 1 and the registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mppt_perturb_observe_adaptive_step import mppt_pkg::*; #(
  parameter int DAC_BITS = DAC_BITS_DEF,
  parameter int SUM_BITS = SUM_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire mppt_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output mppt_out_t                  out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [STEP_W-1:0]          min_step_r;
  logic [STEP_W-1:0]          max_step_r;
  logic [RUN_W-1:0]           run_limit_r;

  logic                       st_valid;
  mppt_stage_t                st_data;
  logic                       advance;
  logic                       decide_held;
  mppt_ctrl_t                 ctrl;
  logic signed [SUM_BITS-1:0] power_sum;
  logic [VSUM_W-1:0]          voltage_sum;
  logic signed [63:0]         psum_ext;
  mppt_trk_t                  trk;
  logic                       out_valid_r;
  mppt_out_t                  out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r  <= MIN_STEP_RST;
      max_step_r  <= MAX_STEP_RST;
      run_limit_r <= RUN_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_STEP:  min_step_r  <= cfg_wdata[STEP_W-1:0];
        CFG_MAX_STEP:  max_step_r  <= cfg_wdata[STEP_W-1:0];
        CFG_RUN_LIMIT: run_limit_r <= cfg_wdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  mppt_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .st_valid (st_valid),
    .st_data  (st_data)
  );

  // a sample always moves on, a decide needs room in the result register
  assign decide_held = st_valid && st_data.decide && out_valid_r && !out_ready;
  assign advance = st_valid && !decide_held;
  assign ctrl.sample_en = advance && !st_data.decide;
  assign ctrl.decide_en = advance && st_data.decide;

  // window sums
  mppt_accum #(
    .SUM_BITS (SUM_BITS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .st_data     (st_data),
    .power_sum   (power_sum),
    .voltage_sum (voltage_sum)
  );

  // direction, step and DAC code
  mppt_track #(
    .DAC_BITS (DAC_BITS),
    .SUM_BITS (SUM_BITS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .decide_en (ctrl.decide_en),
    .min_step  (min_step_r),
    .max_step  (max_step_r),
    .run_limit (run_limit_r),
    .power_sum (power_sum),
    .trk       (trk)
  );

  assign psum_ext = 64'(power_sum);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.decide_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.decide_en) begin
      out_data_r.dac_code       <= trk.dac_code;
      out_data_r.step_size      <= trk.step_size;
      out_data_r.direction_up   <= trk.direction_up;
      out_data_r.window_power   <= psum_ext[WPOW_W-1:0];
      out_data_r.window_voltage <= voltage_sum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `ASSERT_IMPL(a_step_nonzero, out_valid_r, out_data_r.step_size != '0, "zero step reported")
  `ASSERT_IMPL(a_result_from_decide, $rose(out_valid_r), $past(ctrl.decide_en), "stray result")
  `ASSERT_IMPL(a_block_reason, !in_ready, decide_held, "input blocked without a held decide")
  `ASSERT_NEXT(a_stage_holds, st_valid && !advance, st_valid && $stable(st_data), "held request lost")

endmodule

`default_nettype wire

/* bench/tb_mppt_perturb_observe_adaptive_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mppt_perturb_observe_adaptive_step
// Self-checking bench for the adaptive-step perturb and observe tracker.
// Requests go in through a valid/ready sender with random gaps; a built-in
// tracker model predicts each decision result and a checker compares every
// result field with the oldest prediction. Directed tests cover sample
// extremes, the register map, DAC and step limits, back-pressure and long
// full-scale windows; a random test follows with changing register settings.
// ----------------------------------------------------------------------------

module tb_mppt_perturb_observe_adaptive_step;
  import mppt_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int PHASE_ITEMS    = 100;
  localparam int EXT_SAMPLES    = 64;

  // index past the end of the register map, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [63:0] PW_HI = (64'sd1 <<< (WPOW_W - 1)) - 64'sd1;
  localparam logic signed [63:0] PW_LO = -PW_HI - 64'sd1;
  localparam logic [63:0] V_TOP = (64'd1 << VSUM_W) - 64'd1;
  localparam logic [CODE_W-1:0] CODE_TOP = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  mppt_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  mppt_out_t             out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mppt_perturb_observe_adaptive_step uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // tracker model state
  logic signed [WPOW_W-1:0] pw_acc;
  logic signed [WPOW_W-1:0] pw_prev;
  logic [VSUM_W-1:0]        v_acc;
  logic [CODE_W-1:0]        code;
  logic [STEP_W-1:0]        step;
  logic                     dir_up;
  logic                     dir_last;
  logic [RUN_W-1:0]         run_cnt;
  logic [STEP_W-1:0]        min_step_r;
  logic [STEP_W-1:0]        max_step_r;
  logic [RUN_W-1:0]         run_limit_r;

  mppt_out_t decisions_due[$];

  int fail_cnt = 0;
  int gap_max = 12;
  int stall_max = 12;
  bit hold_req = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // model of one accepted request
  task automatic track_request(input mppt_in_t r);
    logic signed [63:0] prod;
    logic signed [63:0] wide;
    logic [63:0] vwide;
    logic [STEP_W:0] grown;
    logic [STEP_W-1:0] floor_s;
    logic [STEP_W-1:0] halved;
    logic [CODE_W:0] raised;
    mppt_out_t res;
    if (r.req_type == REQ_SAMPLE) begin
      prod = 64'($signed(r.shunt_sample)) * 64'($signed({1'b0, r.bus_sample}));
      wide = prod + pw_acc;
      if (wide > PW_HI) wide = PW_HI;
      else if (wide < PW_LO) wide = PW_LO;
      pw_acc = wide[WPOW_W-1:0];
      vwide = 64'(v_acc) + 64'(r.bus_sample);
      if (vwide > V_TOP) vwide = V_TOP;
      v_acc = vwide[VSUM_W-1:0];
      return;
    end
    // power drop reverses, otherwise the run grows
    if (pw_acc < pw_prev) begin
      dir_up = ~dir_up;
      run_cnt = '0;
    end else if (run_cnt < RUN_TOP) begin
      run_cnt++;
    end
    // step adaptation
    if (dir_up == dir_last) begin
      if (run_cnt >= run_limit_r) begin
        if (step < max_step_r) begin
          grown = {step, 1'b0};
          step = (grown > {1'b0, STEP_TOP}) ? STEP_TOP : grown[STEP_W-1:0];
        end
        run_cnt = '0;
      end
    end else begin
      floor_s = (min_step_r == '0) ? STEP_W'(1) : min_step_r;
      if (step > min_step_r) begin
        halved = step >> 1;
        step = (halved < floor_s) ? floor_s : halved;
      end
      if (step == '0) step = STEP_W'(1);
      dir_last = dir_up;
    end
    // move the code, clamped at both ends
    if (dir_up) begin
      raised = {1'b0, code} + {1'b0, step};
      code = (raised < {1'b0, CODE_TOP}) ? raised[CODE_W-1:0] : CODE_TOP;
    end else begin
      code = (code > step) ? code - step : '0;
    end
    res.dac_code       = code;
    res.step_size      = step;
    res.direction_up   = dir_up;
    res.window_power   = pw_acc;
    res.window_voltage = v_acc;
    decisions_due.push_back(res);
    pw_prev = pw_acc;
    pw_acc  = '0;
    v_acc   = '0;
  endtask

  function automatic logic [BUS_W-1:0] pick_bus();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return BUS_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SHUNT_W-1:0] pick_shunt();
    case ($urandom_range(0, 6))
      0: return {1'b1, {(SHUNT_W-1){1'b0}}};
      1: return {1'b0, {(SHUNT_W-1){1'b1}}};
      2: return SHUNT_W'(-$urandom_range(0, 64));
      3: return SHUNT_W'($urandom_range(0, 64));
      default: return SHUNT_W'($urandom);
    endcase
  endfunction

  // send one request, prediction at acceptance
  task automatic send_request(input logic kind, input logic [BUS_W-1:0] bus,
                              input logic signed [SHUNT_W-1:0] shunt);
    mppt_in_t req;
    int gap;
    req.req_type     = kind;
    req.bus_sample   = bus;
    req.shunt_sample = shunt;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    track_request(req);
  endtask

  // let all decisions drain and the input register empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_MIN_STEP:  min_step_r  = data[STEP_W-1:0];
      CFG_MAX_STEP:  max_step_r  = data[STEP_W-1:0];
      CFG_RUN_LIMIT: run_limit_r = data[RUN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] min_v,
                           input logic [CFG_DATA_W-1:0] max_v,
                           input logic [CFG_DATA_W-1:0] run_v);
    wait_idle();
    write_reg(CFG_MIN_STEP, min_v);
    write_reg(CFG_MAX_STEP, max_v);
    write_reg(CFG_RUN_LIMIT, run_v);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // extreme bus and shunt values with the default registers
  task automatic test_sample_extremes();
    send_request(REQ_SAMPLE, '0, '0);
    send_request(REQ_SAMPLE, '1, 16'sh7fff);
    send_request(REQ_SAMPLE, '1, 16'sh8000);
    send_request(REQ_DECIDE, pick_bus(), pick_shunt());
    send_request(REQ_SAMPLE, '1, 16'sh8000);
    send_request(REQ_DECIDE, pick_bus(), pick_shunt());
    send_request(REQ_SAMPLE, 15'h5555, 16'shaaaa);
    send_request(REQ_SAMPLE, 15'h2aaa, 16'sh5555);
    send_request(REQ_SAMPLE, '1, 16'shffff);
    send_request(REQ_DECIDE, '1, 16'sh7fff);
    send_request(REQ_DECIDE, '0, '0);
  endtask

  // run limit takes the low byte, a write past the map changes nothing
  task automatic test_register_map();
    configure(12'd1, 12'd16, 12'h302);
    write_reg(CFG_SPARE, '1);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    repeat (6) send_request(REQ_DECIDE, pick_bus(), pick_shunt());
  endtask

  // doubling past the top, then both code limits
  task automatic test_dac_clamps();
    configure(12'd1, 12'hfff, 12'd0);
    repeat (13) send_request(REQ_DECIDE, pick_bus(), pick_shunt());
    send_request(REQ_SAMPLE, 15'd1, -16'sd1);
    send_request(REQ_DECIDE, pick_bus(), pick_shunt());
    repeat (13) send_request(REQ_DECIDE, pick_bus(), pick_shunt());
  endtask

  // every window lower than the last, step halves down to the floor
  task automatic test_step_floor();
    configure(12'd100, 12'hfff, 12'd255);
    for (int k = 1; k <= 8; k++) begin
      send_request(REQ_SAMPLE, 15'd1, SHUNT_W'(-k));
      send_request(REQ_DECIDE, pick_bus(), pick_shunt());
    end
    // a zero floor behaves as one
    configure(12'd0, 12'hfff, 12'd255);
    for (int k = 9; k <= 16; k++) begin
      send_request(REQ_SAMPLE, 15'd1, SHUNT_W'(-k));
      send_request(REQ_DECIDE, pick_bus(), pick_shunt());
    end
  endtask

  // long result stall while requests keep coming
  task automatic test_backpressure();
    configure(12'd1, 12'd64, 12'd1);
    gap_max = 0;
    stall_max = 0;
    hold_req = 1;
    repeat (40) begin
      if ($urandom_range(0, 2) == 0) send_request(REQ_SAMPLE, pick_bus(), pick_shunt());
      else send_request(REQ_DECIDE, pick_bus(), pick_shunt());
    end
    gap_max = 12;
    stall_max = 12;
  endtask

  // long full-scale windows of both power signs, then pulled back
  task automatic test_power_extremes();
    configure(12'd1, 12'd16, 12'd4);
    gap_max = 0;
    repeat (EXT_SAMPLES) send_request(REQ_SAMPLE, '1, 16'sh7fff);
    repeat (3) send_request(REQ_SAMPLE, '1, 16'sh8000);
    send_request(REQ_DECIDE, pick_bus(), pick_shunt());
    repeat (EXT_SAMPLES) send_request(REQ_SAMPLE, '1, 16'sh8000);
    repeat (3) send_request(REQ_SAMPLE, '1, 16'sh7fff);
    send_request(REQ_DECIDE, pick_bus(), pick_shunt());
    gap_max = 12;
  endtask

  // random windows in phases, each with its own registers and pacing
  task automatic test_random_windows();
    int sent;
    int in_phase;
    int samples;
    int phase;
    logic [CFG_DATA_W-1:0] mn;
    logic [CFG_DATA_W-1:0] mx;
    logic [CFG_DATA_W-1:0] rl;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: mn = 12'd1;
        1: mn = 12'hfff;
        2: mn = 12'd0;
        default: mn = CFG_DATA_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 4))
        0: mx = 12'd1;
        1: mx = 12'hfff;
        2: mx = CFG_DATA_W'($urandom_range(1, 4095));
        default: mx = CFG_DATA_W'($urandom_range(2, 256));
      endcase
      case ($urandom_range(0, 5))
        0: rl = 12'd0;
        1: rl = 12'd1;
        2: rl = 12'd255;
        default: rl = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      rl[CFG_DATA_W-1:RUN_W] = (CFG_DATA_W-RUN_W)'($urandom);
      configure(mn, mx, rl);
      case (phase % 3)
        0: begin gap_max = 12; stall_max = 12; end
        1: begin gap_max = 0;  stall_max = 0;  end
        default: begin gap_max = 3; stall_max = 2; end
      endcase
      in_phase = 0;
      while (in_phase < PHASE_ITEMS) begin
        samples = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        repeat (samples) send_request(REQ_SAMPLE, pick_bus(), pick_shunt());
        send_request(REQ_DECIDE, pick_bus(), pick_shunt());
        in_phase += samples + 1;
      end
      sent += in_phase;
      phase++;
    end
    gap_max = 12;
    stall_max = 12;
  endtask

  // result side ready pattern, a long hold when requested
  initial begin : result_sink
    int pause;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      pause = hold_req ? HOLD_CYCLES : $urandom_range(0, stall_max);
      hold_req = 0;
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // compare each result with the oldest prediction
  always @(posedge clk) begin : result_check
    mppt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decisions_due.size() == 0) begin
        $display("%0t: result with no request pending, actual %0h", $time, out_data);
        fail_cnt++;
      end else begin
        want = decisions_due.pop_front();
        check_field("dac_code", want.dac_code, out_data.dac_code);
        check_field("step_size", want.step_size, out_data.step_size);
        check_field("direction_up", want.direction_up, out_data.direction_up);
        check_field("window_power", want.window_power, out_data.window_power);
        check_field("window_voltage", want.window_voltage, out_data.window_voltage);
      end
    end
  end

  // no acceptance on either side for too long
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // test sequence
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    pw_acc      = '0;
    pw_prev     = '0;
    v_acc       = '0;
    code        = '0;
    step        = MIN_STEP_RST;
    dir_up      = 1'b1;
    dir_last    = 1'b1;
    run_cnt     = '0;
    min_step_r  = MIN_STEP_RST;
    max_step_r  = MAX_STEP_RST;
    run_limit_r = RUN_LIMIT_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sample_extremes();
    test_register_map();
    test_dac_clamps();
    test_step_floor();
    test_backpressure();
    test_power_extremes();
    test_random_windows();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
